// File: rtl/tmprof_pkg.sv
`timescale 1ns / 1ps

package tmprof_pkg;

  typedef logic [63:0] val_t;

  localparam val_t CAP = 64'h4000_0000_0000_0000;
  localparam val_t M32 = 64'h0000_0000_FFFF_FFFF;

  localparam int PC_W = 7;
  typedef logic [PC_W-1:0] pc_t;

  // configuration register indexes
  localparam logic [2:0] REG_DIST  = 3'd0;
  localparam logic [2:0] REG_VO    = 3'd1;
  localparam logic [2:0] REG_VE    = 3'd2;
  localparam logic [2:0] REG_PEAK  = 3'd3;
  localparam logic [2:0] REG_ACCEL = 3'd4;

  // profile status codes
  localparam logic [1:0] STAT_TRAP    = 2'd0;
  localparam logic [1:0] STAT_RAMP    = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP, OP_MOV, OP_ADD, OP_SUB, OP_SADD, OP_SHR1, OP_QMUL, OP_PMUL,
    OP_QDIV, OP_ROOT, OP_USAT, OP_SOUT, OP_CLR
  } op_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_T, SRC_DIST, SRC_VO, SRC_VE, SRC_PK, SRC_A, SRC_VP,
    SRC_T1, SRC_S1, SRC_T2, SRC_S2, SRC_T3, SRC_S3, SRC_X, SRC_Y, SRC_R,
    SRC_VSTEP
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_VP, DST_T1, DST_S1, DST_T2, DST_S2, DST_T3, DST_S3,
    DST_X, DST_Y, DST_R, DST_DUR, DST_MOVD, DST_VEL, DST_POS, DST_ACC
  } dst_t;

  typedef enum logic [3:0] {
    BR_NEXT, BR_GOTO, BR_END, BR_END_INVALID, BR_IF_INVALID, BR_IF_FITS_RAMP,
    BR_PLAN, BR_STOP, BR_STEP, BR_LAST, BR_IF_PH1, BR_IF_PH2
  } br_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    op_t  op;
    dst_t dst;
    src_t sa;
    src_t sb;
    br_t  br;
    pc_t  tgt;
  } uinstr_t;

  typedef struct packed {
    logic go;
    logic load;
    op_t  op;
    dst_t dst;
    src_t sa;
    src_t sb;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic invalid;
    logic s1_gt_dist;
    logic fit;
    logic step_end;
    logic ph1;
    logic ph2;
  } flags_t;

  localparam pc_t L_TRAP = 7'd16;
  localparam pc_t L_PLAN = 7'd17;
  localparam pc_t L_LAST = 7'd33;
  localparam pc_t L_FIN  = 7'd34;
  localparam pc_t L_PH1  = 7'd56;
  localparam pc_t L_PH2  = 7'd66;
  localparam pc_t L_INV  = 7'd72;

  function automatic uinstr_t mk(input op_t op, input dst_t dst, input src_t sa,
                                 input src_t sb, input br_t br, input pc_t tgt);
    uinstr_t u;
    u.op  = op;
    u.dst = dst;
    u.sa  = sa;
    u.sb  = sb;
    u.br  = br;
    u.tgt = tgt;
    return u;
  endfunction

  // sequencer program
  function automatic uinstr_t ucode(input pc_t pc);
    uinstr_t u;
    u = mk(OP_NOP, DST_NONE, SRC_ZERO, SRC_ZERO, BR_END, '0);
    case (pc)
      7'd0:  u = mk(OP_NOP,  DST_NONE, SRC_ZERO, SRC_ZERO, BR_IF_INVALID, L_INV);
      // ramp test with the end velocity
      7'd1:  u = mk(OP_SUB,  DST_X,  SRC_VE, SRC_VO, BR_NEXT, '0);
      7'd2:  u = mk(OP_QDIV, DST_T1, SRC_X,  SRC_A,  BR_NEXT, '0);
      7'd3:  u = mk(OP_QMUL, DST_Y,  SRC_VO, SRC_T1, BR_NEXT, '0);
      7'd4:  u = mk(OP_QMUL, DST_X,  SRC_T1, SRC_T1, BR_NEXT, '0);
      7'd5:  u = mk(OP_QMUL, DST_X,  SRC_A,  SRC_X,  BR_NEXT, '0);
      7'd6:  u = mk(OP_SHR1, DST_X,  SRC_X,  SRC_ZERO, BR_NEXT, '0);
      7'd7:  u = mk(OP_SADD, DST_S1, SRC_Y,  SRC_X,  BR_IF_FITS_RAMP, L_TRAP);
      // ramp only
      7'd8:  u = mk(OP_PMUL, DST_X,  SRC_VO, SRC_VO,   BR_NEXT, '0);
      7'd9:  u = mk(OP_PMUL, DST_Y,  SRC_A,  SRC_DIST, BR_NEXT, '0);
      7'd10: u = mk(OP_ROOT, DST_R,  SRC_X,  SRC_Y,    BR_NEXT, '0);
      7'd11: u = mk(OP_SUB,  DST_X,  SRC_R,  SRC_VO,   BR_NEXT, '0);
      7'd12: u = mk(OP_QDIV, DST_X,  SRC_X,  SRC_A,    BR_NEXT, '0);
      7'd13: u = mk(OP_USAT, DST_DUR,  SRC_X,    SRC_ZERO, BR_NEXT, '0);
      7'd14: u = mk(OP_USAT, DST_MOVD, SRC_DIST, SRC_ZERO, BR_NEXT, '0);
      7'd15: u = mk(OP_NOP,  DST_NONE, SRC_ZERO, SRC_ZERO, BR_GOTO, L_PH1);
      // trapezoid planning with peak reduction
      7'd16: u = mk(OP_MOV,  DST_VP, SRC_PK, SRC_ZERO, BR_NEXT, '0);
      7'd17: u = mk(OP_SUB,  DST_X,  SRC_VP, SRC_VO, BR_NEXT, '0);
      7'd18: u = mk(OP_QDIV, DST_T1, SRC_X,  SRC_A,  BR_NEXT, '0);
      7'd19: u = mk(OP_QMUL, DST_Y,  SRC_VO, SRC_T1, BR_NEXT, '0);
      7'd20: u = mk(OP_QMUL, DST_X,  SRC_T1, SRC_T1, BR_NEXT, '0);
      7'd21: u = mk(OP_QMUL, DST_X,  SRC_A,  SRC_X,  BR_NEXT, '0);
      7'd22: u = mk(OP_SHR1, DST_X,  SRC_X,  SRC_ZERO, BR_NEXT, '0);
      7'd23: u = mk(OP_SADD, DST_S1, SRC_Y,  SRC_X,  BR_NEXT, '0);
      7'd24: u = mk(OP_SUB,  DST_X,  SRC_VP, SRC_VE, BR_NEXT, '0);
      7'd25: u = mk(OP_QDIV, DST_T3, SRC_X,  SRC_A,  BR_NEXT, '0);
      7'd26: u = mk(OP_QMUL, DST_Y,  SRC_VE, SRC_T3, BR_NEXT, '0);
      7'd27: u = mk(OP_QMUL, DST_X,  SRC_T3, SRC_T3, BR_NEXT, '0);
      7'd28: u = mk(OP_QMUL, DST_X,  SRC_A,  SRC_X,  BR_NEXT, '0);
      7'd29: u = mk(OP_SHR1, DST_X,  SRC_X,  SRC_ZERO, BR_NEXT, '0);
      7'd30: u = mk(OP_SADD, DST_S3, SRC_Y,  SRC_X,  BR_PLAN, L_FIN);
      7'd31: u = mk(OP_NOP,  DST_NONE, SRC_ZERO, SRC_ZERO, BR_STOP, L_LAST);
      7'd32: u = mk(OP_SUB,  DST_VP, SRC_VP, SRC_VSTEP, BR_STEP, L_PLAN);
      7'd33: u = mk(OP_MOV,  DST_VP, SRC_VE, SRC_ZERO, BR_LAST, L_PLAN);
      // totals
      7'd34: u = mk(OP_ADD,  DST_X,  SRC_S1,   SRC_S3, BR_NEXT, '0);
      7'd35: u = mk(OP_SUB,  DST_S2, SRC_DIST, SRC_X,  BR_NEXT, '0);
      7'd36: u = mk(OP_QDIV, DST_T2, SRC_S2,   SRC_VP, BR_NEXT, '0);
      7'd37: u = mk(OP_SADD, DST_X,  SRC_T1,   SRC_T2, BR_NEXT, '0);
      7'd38: u = mk(OP_SADD, DST_X,  SRC_X,    SRC_T3, BR_NEXT, '0);
      7'd39: u = mk(OP_USAT, DST_DUR, SRC_X,   SRC_ZERO, BR_NEXT, '0);
      7'd40: u = mk(OP_SADD, DST_X,  SRC_S1,   SRC_S2, BR_NEXT, '0);
      7'd41: u = mk(OP_SADD, DST_X,  SRC_X,    SRC_S3, BR_NEXT, '0);
      7'd42: u = mk(OP_USAT, DST_MOVD, SRC_X,  SRC_ZERO, BR_IF_PH1, L_PH1);
      7'd43: u = mk(OP_NOP,  DST_NONE, SRC_ZERO, SRC_ZERO, BR_IF_PH2, L_PH2);
      // decelerate phase
      7'd44: u = mk(OP_SUB,  DST_X,  SRC_T,  SRC_T1, BR_NEXT, '0);
      7'd45: u = mk(OP_SUB,  DST_X,  SRC_X,  SRC_T2, BR_NEXT, '0);
      7'd46: u = mk(OP_QMUL, DST_Y,  SRC_A,  SRC_X,  BR_NEXT, '0);
      7'd47: u = mk(OP_SOUT, DST_VEL, SRC_VP, SRC_Y, BR_NEXT, '0);
      7'd48: u = mk(OP_QMUL, DST_Y,  SRC_VP, SRC_X,  BR_NEXT, '0);
      7'd49: u = mk(OP_QMUL, DST_X,  SRC_X,  SRC_X,  BR_NEXT, '0);
      7'd50: u = mk(OP_QMUL, DST_X,  SRC_A,  SRC_X,  BR_NEXT, '0);
      7'd51: u = mk(OP_SHR1, DST_X,  SRC_X,  SRC_ZERO, BR_NEXT, '0);
      7'd52: u = mk(OP_SADD, DST_R,  SRC_S1, SRC_S2, BR_NEXT, '0);
      7'd53: u = mk(OP_SADD, DST_Y,  SRC_R,  SRC_Y,  BR_NEXT, '0);
      7'd54: u = mk(OP_SOUT, DST_POS, SRC_Y, SRC_X,  BR_NEXT, '0);
      7'd55: u = mk(OP_SOUT, DST_ACC, SRC_ZERO, SRC_A, BR_END, '0);
      // accelerate phase
      7'd56: u = mk(OP_QMUL, DST_X,  SRC_A,  SRC_T,  BR_NEXT, '0);
      7'd57: u = mk(OP_SADD, DST_X,  SRC_VO, SRC_X,  BR_NEXT, '0);
      7'd58: u = mk(OP_SOUT, DST_VEL, SRC_X, SRC_ZERO, BR_NEXT, '0);
      7'd59: u = mk(OP_QMUL, DST_Y,  SRC_VO, SRC_T,  BR_NEXT, '0);
      7'd60: u = mk(OP_QMUL, DST_X,  SRC_T,  SRC_T,  BR_NEXT, '0);
      7'd61: u = mk(OP_QMUL, DST_X,  SRC_A,  SRC_X,  BR_NEXT, '0);
      7'd62: u = mk(OP_SHR1, DST_X,  SRC_X,  SRC_ZERO, BR_NEXT, '0);
      7'd63: u = mk(OP_SADD, DST_X,  SRC_Y,  SRC_X,  BR_NEXT, '0);
      7'd64: u = mk(OP_SOUT, DST_POS, SRC_X, SRC_ZERO, BR_NEXT, '0);
      7'd65: u = mk(OP_SOUT, DST_ACC, SRC_A, SRC_ZERO, BR_END, '0);
      // cruise phase
      7'd66: u = mk(OP_SOUT, DST_VEL, SRC_VP, SRC_ZERO, BR_NEXT, '0);
      7'd67: u = mk(OP_SUB,  DST_X,  SRC_T,  SRC_T1, BR_NEXT, '0);
      7'd68: u = mk(OP_QMUL, DST_X,  SRC_VP, SRC_X,  BR_NEXT, '0);
      7'd69: u = mk(OP_SADD, DST_X,  SRC_S1, SRC_X,  BR_NEXT, '0);
      7'd70: u = mk(OP_SOUT, DST_POS, SRC_X, SRC_ZERO, BR_NEXT, '0);
      7'd71: u = mk(OP_SOUT, DST_ACC, SRC_ZERO, SRC_ZERO, BR_END, '0);
      // invalid setup
      7'd72: u = mk(OP_CLR,  DST_NONE, SRC_ZERO, SRC_ZERO, BR_END_INVALID, '0);
      default: u = mk(OP_NOP, DST_NONE, SRC_ZERO, SRC_ZERO, BR_END, '0);
    endcase
    return u;
  endfunction

endpackage

// File: rtl/tmprof_mul.sv
`timescale 1ns / 1ps

// 64 x 64 product from four 32 x 32 partial products
module tmprof_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [127:0]  prod
);

  logic        run;
  logic [2:0]  ph;
  logic [63:0] ax;
  logic [63:0] bx;
  logic [63:0] pp;
  logic [1:0]  psh;
  logic [31:0] ah;
  logic [31:0] bh;
  logic [127:0] pp_sh;

  assign ah = ph[1] ? ax[63:32] : ax[31:0];
  assign bh = ph[0] ? bx[63:32] : bx[31:0];

  always_comb begin
    case (psh)
      2'd0:    pp_sh = {64'b0, pp};
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      default: pp_sh = {pp, 64'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      ph   <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        ph  <= '0;
      end else if (run) begin
        ph <= ph + 3'd1;
        if (ph == 3'd4) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ax   <= a;
      bx   <= b;
      prod <= '0;
    end else if (run) begin
      if (ph != 3'd4) begin
        pp  <= 64'(ah) * 64'(bh);
        psh <= {1'b0, ph[1]} + {1'b0, ph[0]};
      end
      // add the previous partial product
      if (ph != 3'd0) begin
        prod <= prod + pp_sh;
      end
    end
  end

endmodule

// File: rtl/tmprof_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit a cycle
module tmprof_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot
);

  logic        run;
  logic [5:0]  cnt;
  logic [64:0] rem;
  logic [63:0] dvs;
  logic [64:0] rem_s;
  logic        fits;

  assign rem_s = {rem[63:0], quot[63]};
  assign fits  = rem_s >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of quot as quotient bits shift in
  always_ff @(posedge clk) begin
    if (go) begin
      rem  <= '0;
      dvs  <= divisor;
      quot <= dividend;
    end else if (run) begin
      rem  <= fits ? rem_s - {1'b0, dvs} : rem_s;
      quot <= {quot[62:0], fits};
    end
  end

endmodule

// File: rtl/tmprof_root.sv
`timescale 1ns / 1ps

// floor square root of a 66-bit radicand, one root bit a cycle
module tmprof_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [65:0] rad,
  output logic        done,
  output logic [63:0] root_out
);

  localparam int STEPS = 33;

  logic        run;
  logic [5:0]  cnt;
  logic [65:0] rad_sh;
  logic [37:0] rem;
  logic [33:0] root;
  logic [37:0] rem_s;
  logic [37:0] trial;
  logic        fits;

  assign rem_s    = {rem[35:0], rad_sh[65:64]};
  assign trial    = {2'b0, root, 2'b01};
  assign fits     = rem_s >= trial;
  assign root_out = {30'b0, root};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
    end else if (run) begin
      rad_sh <= {rad_sh[63:0], 2'b00};
      rem    <= fits ? rem_s - trial : rem_s;
      root   <= {root[32:0], fits};
    end
  end

endmodule

// File: rtl/tmprof_dp.sv
`timescale 1ns / 1ps

module tmprof_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [31:0]          query_time,
  input  tmprof_pkg::cmd_t     cmd,
  output tmprof_pkg::flags_t   flags,
  output logic [31:0]          move_duration,
  output logic [31:0]          move_distance,
  output logic signed [31:0]   velocity_out,
  output logic signed [31:0]   position_out,
  output logic signed [31:0]   accel_out
);

  localparam logic [63:0] VSTEP =
    64'((((64'd1 << FRAC_BITS) + 64'd50) / 64'd100));

  logic [31:0] total_distance;
  logic [31:0] start_velocity;
  logic [31:0] end_velocity;
  logic [31:0] peak_velocity;
  logic [31:0] accel_rate;
  logic [31:0] ve_c;

  tmprof_pkg::val_t t_q, vp, t1, s1, t2, s2, t3, s3, x, y, r;
  tmprof_pkg::val_t opa, opb, fast_val, wb_val, qmul_val, qdiv_val;
  logic             wb_en;
  logic             fast;
  logic             done_q;

  logic             mul_go, div_go, root_go;
  logic             mul_done, div_done, root_done;
  logic [127:0]     prod;
  logic [63:0]      quot;
  logic [63:0]      root_val;
  logic [65:0]      rad;
  logic [64:0]      sum13;
  logic [64:0]      sum12;
  logic [63:0]      dv;

  assign ve_c = (end_velocity < peak_velocity) ? end_velocity : peak_velocity;

  function automatic tmprof_pkg::val_t pick(input tmprof_pkg::src_t s);
    tmprof_pkg::val_t v;
    case (s)
      tmprof_pkg::SRC_ZERO:  v = '0;
      tmprof_pkg::SRC_T:     v = t_q;
      tmprof_pkg::SRC_DIST:  v = {32'b0, total_distance};
      tmprof_pkg::SRC_VO:    v = {32'b0, start_velocity};
      tmprof_pkg::SRC_VE:    v = {32'b0, ve_c};
      tmprof_pkg::SRC_PK:    v = {32'b0, peak_velocity};
      tmprof_pkg::SRC_A:     v = {32'b0, accel_rate};
      tmprof_pkg::SRC_VP:    v = vp;
      tmprof_pkg::SRC_T1:    v = t1;
      tmprof_pkg::SRC_S1:    v = s1;
      tmprof_pkg::SRC_T2:    v = t2;
      tmprof_pkg::SRC_S2:    v = s2;
      tmprof_pkg::SRC_T3:    v = t3;
      tmprof_pkg::SRC_S3:    v = s3;
      tmprof_pkg::SRC_X:     v = x;
      tmprof_pkg::SRC_Y:     v = y;
      tmprof_pkg::SRC_R:     v = r;
      tmprof_pkg::SRC_VSTEP: v = VSTEP;
      default:               v = '0;
    endcase
    return v;
  endfunction

  // signed 32-bit result of pos - neg, saturated
  function automatic logic [31:0] s32out(input tmprof_pkg::val_t pos,
                                         input tmprof_pkg::val_t neg);
    logic [63:0] d;
    logic [31:0] o;
    if (pos >= neg) begin
      d = pos - neg;
      o = (d > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : d[31:0];
    end else begin
      d = neg - pos;
      o = (d >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - d[31:0]);
    end
    return o;
  endfunction

  assign opa = pick(cmd.sa);
  assign opb = pick(cmd.sb);

  always_comb begin
    fast     = 1'b1;
    fast_val = '0;
    case (cmd.op)
      tmprof_pkg::OP_MOV:  fast_val = opa;
      tmprof_pkg::OP_ADD:  fast_val = opa + opb;
      tmprof_pkg::OP_SUB:  fast_val = opa - opb;
      tmprof_pkg::OP_SADD: begin
        fast_val = opa + opb;
        if (fast_val > tmprof_pkg::CAP) fast_val = tmprof_pkg::CAP;
      end
      tmprof_pkg::OP_SHR1: fast_val = opa >> 1;
      tmprof_pkg::OP_USAT: fast_val = (opa > tmprof_pkg::M32) ? tmprof_pkg::M32 : opa;
      tmprof_pkg::OP_SOUT: fast_val = {32'b0, s32out(opa, opb)};
      tmprof_pkg::OP_QMUL,
      tmprof_pkg::OP_PMUL,
      tmprof_pkg::OP_QDIV,
      tmprof_pkg::OP_ROOT: fast = 1'b0;
      default:             fast_val = '0;
    endcase
  end

  // fixed-point product: saturate on overflow, drop fraction bits
  always_comb begin
    if (prod[127:64+FRAC_BITS] != '0) begin
      qmul_val = tmprof_pkg::CAP;
    end else begin
      qmul_val = prod[64+FRAC_BITS-1:FRAC_BITS];
      if (qmul_val > tmprof_pkg::CAP) qmul_val = tmprof_pkg::CAP;
    end
  end

  always_comb begin
    if (opb == '0 || opa[63:64-FRAC_BITS] != '0) begin
      qdiv_val = tmprof_pkg::CAP;
    end else begin
      qdiv_val = (quot > tmprof_pkg::CAP) ? tmprof_pkg::CAP : quot;
    end
  end

  assign mul_go  = cmd.go && (cmd.op == tmprof_pkg::OP_QMUL || cmd.op == tmprof_pkg::OP_PMUL);
  assign div_go  = cmd.go && (cmd.op == tmprof_pkg::OP_QDIV);
  assign root_go = cmd.go && (cmd.op == tmprof_pkg::OP_ROOT);
  assign dv      = opa << FRAC_BITS;
  assign rad     = {2'b00, opa} + {1'b0, opb, 1'b0};

  tmprof_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (opa),
    .b    (opb),
    .done (mul_done),
    .prod (prod)
  );

  tmprof_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (dv),
    .divisor  (opb),
    .done     (div_done),
    .quot     (quot)
  );

  tmprof_root u_root (
    .clk      (clk),
    .rst      (rst),
    .go       (root_go),
    .rad      (rad),
    .done     (root_done),
    .root_out (root_val)
  );

  always_comb begin
    wb_en  = 1'b0;
    wb_val = fast_val;
    case (cmd.op)
      tmprof_pkg::OP_QMUL: begin
        wb_en  = mul_done;
        wb_val = qmul_val;
      end
      tmprof_pkg::OP_PMUL: begin
        wb_en  = mul_done;
        wb_val = prod[63:0];
      end
      tmprof_pkg::OP_QDIV: begin
        wb_en  = div_done;
        wb_val = qdiv_val;
      end
      tmprof_pkg::OP_ROOT: begin
        wb_en  = root_done;
        wb_val = root_val;
      end
      default: wb_en = cmd.go && fast;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_distance <= '0;
      start_velocity <= '0;
      end_velocity   <= '0;
      peak_velocity  <= '0;
      accel_rate     <= '0;
      done_q         <= 1'b0;
    end else begin
      done_q <= (cmd.go && fast) || mul_done || div_done || root_done;
      if (cfg_write) begin
        case (cfg_index)
          tmprof_pkg::REG_DIST:  total_distance <= cfg_data;
          tmprof_pkg::REG_VO:    start_velocity <= cfg_data;
          tmprof_pkg::REG_VE:    end_velocity   <= cfg_data;
          tmprof_pkg::REG_PEAK:  peak_velocity  <= cfg_data;
          tmprof_pkg::REG_ACCEL: accel_rate     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) t_q <= {32'b0, query_time};
    if (cmd.go && cmd.op == tmprof_pkg::OP_CLR) begin
      move_duration <= '0;
      move_distance <= '0;
      velocity_out  <= '0;
      position_out  <= '0;
      accel_out     <= '0;
    end
    if (wb_en) begin
      case (cmd.dst)
        tmprof_pkg::DST_VP:   vp <= wb_val;
        tmprof_pkg::DST_T1:   t1 <= wb_val;
        tmprof_pkg::DST_S1:   s1 <= wb_val;
        tmprof_pkg::DST_T2:   t2 <= wb_val;
        tmprof_pkg::DST_S2:   s2 <= wb_val;
        tmprof_pkg::DST_T3:   t3 <= wb_val;
        tmprof_pkg::DST_S3:   s3 <= wb_val;
        tmprof_pkg::DST_X:    x  <= wb_val;
        tmprof_pkg::DST_Y:    y  <= wb_val;
        tmprof_pkg::DST_R:    r  <= wb_val;
        tmprof_pkg::DST_DUR:  move_duration <= wb_val[31:0];
        tmprof_pkg::DST_MOVD: move_distance <= wb_val[31:0];
        tmprof_pkg::DST_VEL:  velocity_out  <= wb_val[31:0];
        tmprof_pkg::DST_POS:  position_out  <= wb_val[31:0];
        tmprof_pkg::DST_ACC:  accel_out     <= wb_val[31:0];
        default: ;
      endcase
    end
  end

  assign sum13 = {1'b0, s1} + {1'b0, s3};
  assign sum12 = {1'b0, t1} + {1'b0, t2};

  assign flags.done       = done_q;
  assign flags.invalid    = (accel_rate == '0) || (total_distance == '0) ||
                            (peak_velocity == '0) || (ve_c < start_velocity);
  assign flags.s1_gt_dist = s1 > {32'b0, total_distance};
  assign flags.fit        = sum13 <= {33'b0, total_distance};
  assign flags.step_end   = (vp - {32'b0, ve_c}) <= VSTEP;
  assign flags.ph1        = t_q <= t1;
  assign flags.ph2        = {1'b0, t_q} < sum12;

endmodule

// File: rtl/tmprof_ctrl.sv
`timescale 1ns / 1ps

module tmprof_ctrl #(
  parameter int MAX_REDUCE_STEPS = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tmprof_pkg::flags_t  flags,
  output tmprof_pkg::cmd_t    cmd,
  output logic                busy,
  output logic                done,
  output logic [1:0]          profile_status
);

  localparam int CNT_W = $clog2(MAX_REDUCE_STEPS + 1);

  tmprof_pkg::ctrl_state_t state, state_next;
  tmprof_pkg::pc_t         pc, pc_next;
  logic [CNT_W-1:0]        n, n_next;
  logic                    last, last_next;
  logic                    ramp, ramp_next;
  logic [1:0]              stat, stat_next;
  tmprof_pkg::uinstr_t     ui;
  tmprof_pkg::pc_t         pc_inc;

  assign ui     = tmprof_pkg::ucode(pc);
  assign pc_inc = pc + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmprof_pkg::ST_IDLE;
      pc    <= '0;
      n     <= '0;
      last  <= 1'b0;
      ramp  <= 1'b0;
      stat  <= tmprof_pkg::STAT_TRAP;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      n     <= n_next;
      last  <= last_next;
      ramp  <= ramp_next;
      stat  <= stat_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    n_next     = n;
    last_next  = last;
    ramp_next  = ramp;
    stat_next  = stat;
    cmd.go     = 1'b0;
    cmd.load   = 1'b0;
    cmd.op     = ui.op;
    cmd.dst    = ui.dst;
    cmd.sa     = ui.sa;
    cmd.sb     = ui.sb;
    done       = 1'b0;
    case (state)
      tmprof_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          pc_next    = '0;
          n_next     = '0;
          last_next  = 1'b0;
          ramp_next  = 1'b0;
          state_next = tmprof_pkg::ST_ISSUE;
        end
      end
      tmprof_pkg::ST_ISSUE: begin
        cmd.go     = 1'b1;
        state_next = tmprof_pkg::ST_WAIT;
      end
      tmprof_pkg::ST_WAIT: begin
        if (flags.done) begin
          state_next = tmprof_pkg::ST_ISSUE;
          pc_next    = pc_inc;
          case (ui.br)
            tmprof_pkg::BR_NEXT: pc_next = pc_inc;
            tmprof_pkg::BR_GOTO: pc_next = ui.tgt;
            tmprof_pkg::BR_END: begin
              stat_next  = ramp ? tmprof_pkg::STAT_RAMP : tmprof_pkg::STAT_TRAP;
              state_next = tmprof_pkg::ST_DONE;
            end
            tmprof_pkg::BR_END_INVALID: begin
              stat_next  = tmprof_pkg::STAT_INVALID;
              state_next = tmprof_pkg::ST_DONE;
            end
            tmprof_pkg::BR_IF_INVALID: if (flags.invalid) pc_next = ui.tgt;
            tmprof_pkg::BR_IF_FITS_RAMP: begin
              if (!flags.s1_gt_dist) pc_next = ui.tgt;
              else ramp_next = 1'b1;
            end
            tmprof_pkg::BR_PLAN: if (flags.fit || last) pc_next = ui.tgt;
            tmprof_pkg::BR_STOP: begin
              if (n >= CNT_W'(MAX_REDUCE_STEPS) || flags.step_end) pc_next = ui.tgt;
            end
            tmprof_pkg::BR_STEP: begin
              n_next  = n + 1'b1;
              pc_next = ui.tgt;
            end
            tmprof_pkg::BR_LAST: begin
              last_next = 1'b1;
              pc_next   = ui.tgt;
            end
            tmprof_pkg::BR_IF_PH1: if (flags.ph1) pc_next = ui.tgt;
            tmprof_pkg::BR_IF_PH2: if (flags.ph2) pc_next = ui.tgt;
            default: pc_next = pc_inc;
          endcase
        end
      end
      tmprof_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = tmprof_pkg::ST_IDLE;
      end
      default: state_next = tmprof_pkg::ST_IDLE;
    endcase
  end

  assign busy           = state != tmprof_pkg::ST_IDLE;
  assign profile_status = stat;

endmodule

// File: rtl/trapezoid_motion_profile_core.sv
`timescale 1ns / 1ps

// Trapezoidal velocity profile evaluator. Pulse start with query_time while
// busy is low; done is high for exactly one cycle once the result is on the
// output ports, and the result must be captured then, as the block cannot be stalled.
// One query at a time. A query runs a microcoded sequence over a shared
// multiplier, a bit-serial divider and a bit-serial square-root unit. A
// trapezoid whose peak does not fit has its peak lowered in 0.01 steps (up
// to MAX_REDUCE_STEPS steps), and an invalid setup takes a short path that
// clears the outputs.
// Configuration writes land at once and are meant for when busy is low.
module trapezoid_motion_profile_core #(
  parameter int FRAC_BITS        = 16,
  parameter int MAX_REDUCE_STEPS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               start,
  input  logic [31:0]        query_time,
  output logic               busy,
  output logic               done,
  output logic [31:0]        move_duration,
  output logic [31:0]        move_distance,
  output logic signed [31:0] velocity_out,
  output logic signed [31:0] position_out,
  output logic signed [31:0] accel_out,
  output logic [1:0]         profile_status
);

  tmprof_pkg::cmd_t   cmd;
  tmprof_pkg::flags_t flags;

  tmprof_ctrl #(
    .MAX_REDUCE_STEPS (MAX_REDUCE_STEPS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .flags          (flags),
    .cmd            (cmd),
    .busy           (busy),
    .done           (done),
    .profile_status (profile_status)
  );

  tmprof_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .query_time    (query_time),
    .cmd           (cmd),
    .flags         (flags),
    .move_duration (move_duration),
    .move_distance (move_distance),
    .velocity_out  (velocity_out),
    .position_out  (position_out),
    .accel_out     (accel_out)
  );

endmodule
